// File: hdl/kvcs_pkg.sv
// shared types, constants and address layout for the kv cache scatter addresser
package kvcs_pkg;

  // memory geometry
  localparam int BANK_GROUPS     = 4;
  localparam int BANKS_PER_GROUP = 4;
  localparam int WORD_ELEMS      = 16;
  localparam int COLUMNS         = 32;
  localparam int ROW_BITS        = 16;
  localparam int RANK_BITS       = 0;
  localparam int BANKS_PER_CH    = BANK_GROUPS * BANKS_PER_GROUP;
  localparam int CH_MAX          = 31;

  // packed address field widths
  localparam int CH_B  = 5;
  localparam int BG_B  = $clog2(BANK_GROUPS);
  localparam int BK_B  = $clog2(BANKS_PER_GROUP);
  localparam int COL_B = $clog2(COLUMNS);
  localparam int OFF_B = $clog2(2 * WORD_ELEMS);
  localparam int SH_COL = OFF_B;
  localparam int SH_ROW = SH_COL + COL_B;
  localparam int SH_BK  = SH_ROW + ROW_BITS;
  localparam int SH_BG  = SH_BK + BK_B;
  localparam int SH_CH  = SH_BG + BG_B + RANK_BITS;

  // register widths
  localparam int HC_W   = 9;
  localparam int SL_W   = 17;
  localparam int HD_W   = 11;
  localparam int CU_W   = 6;
  localparam int FC_W   = 5;
  localparam int RR_W   = 16;
  localparam int CFG_DW = 17;
  localparam int CFG_IW = 3;

  // derived arithmetic widths
  localparam int P1_W    = HC_W + SL_W;
  localparam int PB_W    = P1_W + HD_W;
  localparam int SD_W    = SL_W + HD_W;
  localparam int SHARE_W = PB_W - $clog2(BANKS_PER_CH);
  localparam int LOG_W   = 8 + SD_W + 1;
  localparam int REM_W   = SHARE_W + 1;
  localparam int OFS_W   = 8 + SHARE_W + 1;
  localparam int ROWF_W  = OFS_W + 1;
  localparam int LANE_KW = ($clog2(WORD_ELEMS) < 1) ? 1 : $clog2(WORD_ELEMS);

  // register indexes
  localparam logic [CFG_IW-1:0] REG_HEAD_COUNT    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SEQ_LENGTH    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_HEAD_DIM      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CHANNELS_USED = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FIRST_CHANNEL = 3'd4;
  localparam logic [CFG_IW-1:0] REG_REGION_ROW    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHARE0   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  batch;
    logic [7:0]  head;
    logic [15:0] seq_pos;
    logic [9:0]  dim_index;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  channel;
    logic [1:0]  bank_group;
    logic [1:0]  bank_num;
    logic [15:0] dram_row;
    logic [4:0]  column;
    logic [3:0]  lane;
    logic [39:0] byte_address;
    logic [15:0] data_out;
    logic [1:0]  status;
  } out_word_t;

  // per-item data carried alongside the address math
  typedef struct packed {
    logic               kind;
    logic [7:0]         batch;
    logic [LANE_KW-1:0] lane_k;
    logic [15:0]        value;
  } side_t;

  typedef struct packed {
    logic [LOG_W-1:0] logical;
    side_t            side;
  } mid_word_t;

  // configuration and derived values seen by the datapath
  typedef struct packed {
    logic [SL_W-1:0]    seq_length;
    logic [HD_W-1:0]    head_dim;
    logic [SD_W-1:0]    sd;
    logic [SHARE_W-1:0] share;
    logic [CU_W-1:0]    channels_used;
    logic [FC_W-1:0]    first_channel;
    logic [RR_W-1:0]    region_row;
  } cfg_t;

endpackage

// File: hdl/kvcs_cfg.sv
// configuration registers and the sequencer that derives the bank share
module kvcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [kvcs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kvcs_pkg::CFG_DW-1:0] cfg_data,
  output kvcs_pkg::cfg_t              cfg,
  output logic                        busy
);
  import kvcs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PROD, S_DIV} seq_state_t;

  seq_state_t         state_r;
  logic [HC_W-1:0]    hc_r;
  logic [SL_W-1:0]    sl_r;
  logic [HD_W-1:0]    hd_r;
  logic [CU_W-1:0]    cu_r;
  logic [FC_W-1:0]    fc_r;
  logic [RR_W-1:0]    rr_r;
  logic [P1_W-1:0]    p1_r;
  logic [SD_W-1:0]    sd_r;
  logic [SHARE_W-1:0] share_r;
  logic [SHARE_W-1:0] dq_r;
  logic [CU_W:0]      rem_r;
  logic [5:0]         cnt_r;
  logic [SHARE_W-1:0] dq_nxt;
  logic [CU_W:0]      rem_nxt;
  logic [CU_W:0]      trial;
  logic [PB_W-1:0]    pb;

  // one quotient bit per cycle of per_batch / banks over channels_used
  always_comb begin
    trial = {rem_r[CU_W-1:0], dq_r[SHARE_W-1]};
    if (trial >= {1'b0, cu_r}) begin
      rem_nxt = trial - {1'b0, cu_r};
      dq_nxt  = {dq_r[SHARE_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      dq_nxt  = {dq_r[SHARE_W-2:0], 1'b0};
    end
  end

  assign pb = p1_r * PB_W'(hd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hc_r    <= HC_W'(1);
      sl_r    <= SL_W'(1);
      hd_r    <= HD_W'(16);
      cu_r    <= CU_W'(1);
      fc_r    <= '0;
      rr_r    <= '0;
      sd_r    <= SD_W'(16);
      share_r <= SHARE_W'(1);
      p1_r    <= '0;
      dq_r    <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD_COUNT:    hc_r <= cfg_data[HC_W-1:0];
        REG_SEQ_LENGTH:    sl_r <= cfg_data[SL_W-1:0];
        REG_HEAD_DIM:      hd_r <= cfg_data[HD_W-1:0];
        REG_CHANNELS_USED: cu_r <= cfg_data[CU_W-1:0];
        REG_FIRST_CHANNEL: fc_r <= cfg_data[FC_W-1:0];
        REG_REGION_ROW:    rr_r <= cfg_data[RR_W-1:0];
        default: ;
      endcase
      state_r <= S_MUL;
    end else begin
      case (state_r)
        S_MUL: begin
          p1_r    <= P1_W'(hc_r) * P1_W'(sl_r);
          state_r <= S_PROD;
        end
        S_PROD: begin
          sd_r    <= SD_W'(sl_r) * SD_W'(hd_r);
          dq_r    <= SHARE_W'(pb / BANKS_PER_CH);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(SHARE_W - 1)) begin
            share_r <= (cu_r == '0) ? '0 : dq_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cfg.seq_length    = sl_r;
    cfg.head_dim      = hd_r;
    cfg.sd            = sd_r;
    cfg.share         = share_r;
    cfg.channels_used = cu_r;
    cfg.first_channel = fc_r;
    cfg.region_row    = rr_r;
  end
endmodule

// File: hdl/kvcs_front.sv
// front end: takes input words and forms the logical element index
module kvcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  kvcs_pkg::in_word_t  in_word,
  input  kvcs_pkg::cfg_t      cfg,
  output logic                ready,
  output logic                mq_push,
  output kvcs_pkg::mid_word_t mq_wdata,
  input  logic                mq_full
);
  import kvcs_pkg::*;

  logic             s1_v_r, s2_v_r;
  logic [LOG_W-1:0] hp_r, t_r;
  logic [15:0]      add_r;
  side_t            s1_side_r, s2_side_r;
  logic [LOG_W-1:0] logical_r;
  logic             adv;
  logic [9:0]       d0;

  assign adv   = !s2_v_r || !mq_full;
  assign ready = adv;
  assign d0    = 10'((in_word.dim_index / WORD_ELEMS) * WORD_ELEMS);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
    end
  end

  // stage 1 products, stage 2 sum
  always_ff @(posedge clk) begin
    if (adv) begin
      hp_r <= LOG_W'(in_word.head) * LOG_W'(cfg.sd);
      if (in_word.kind) begin
        t_r   <= LOG_W'(in_word.seq_pos) * LOG_W'(cfg.head_dim);
        add_r <= 16'(d0);
      end else begin
        t_r   <= LOG_W'(in_word.dim_index) * LOG_W'(cfg.seq_length);
        add_r <= in_word.seq_pos;
      end
      s1_side_r.kind   <= in_word.kind;
      s1_side_r.batch  <= in_word.batch;
      s1_side_r.lane_k <= LANE_KW'(in_word.dim_index % WORD_ELEMS);
      s1_side_r.value  <= in_word.value;
      logical_r <= hp_r + t_r + LOG_W'(add_r);
      s2_side_r <= s1_side_r;
    end
  end

  assign mq_push           = s2_v_r && !mq_full;
  assign mq_wdata.logical  = logical_r;
  assign mq_wdata.side     = s2_side_r;
endmodule

// File: hdl/kvcs_midq.sv
// four-entry queue between front and back
module kvcs_midq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kvcs_pkg::mid_word_t wdata,
  output logic                full,
  input  logic                pop,
  output kvcs_pkg::mid_word_t rdata,
  output logic                empty
);
  import kvcs_pkg::*;

  mid_word_t  mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rdata = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule

// File: hdl/kvcs_back.sv
// back end: pipelined divide by share, address packing and result queue
module kvcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kvcs_pkg::mid_word_t  mq_rdata,
  input  logic                 mq_empty,
  output logic                 mq_pop,
  input  kvcs_pkg::cfg_t       cfg,
  output logic                 out_empty,
  input  logic                 out_pop,
  output kvcs_pkg::out_word_t  out_word
);
  import kvcs_pkg::*;

  localparam int NST = LOG_W + 1;

  logic               v_r   [NST];
  logic [REM_W-1:0]   rem_r [NST];
  logic [LOG_W-1:0]   n_r   [NST];
  side_t              sd_r  [NST];
  logic               m_v_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [LOG_W-1:0]   q_r;
  side_t              m_side_r;
  logic               adv;
  logic               oq_full;
  out_word_t          res;
  out_word_t          oq_r [2];
  logic               owp_r, orp_r;
  logic [1:0]         ocnt_r;
  logic               o_push;

  // one restoring divide step: next partial remainder and quotient bit
  function automatic logic [REM_W+LOG_W-1:0] div_step(
    input logic [REM_W-1:0]   rem,
    input logic [LOG_W-1:0]   n,
    input logic [SHARE_W-1:0] d
  );
    logic [REM_W-1:0] t;
    logic             qb;
    t  = {rem[REM_W-2:0], n[LOG_W-1]};
    qb = (t >= {1'b0, d});
    if (qb) t = t - {1'b0, d};
    return {t, n[LOG_W-2:0], qb};
  endfunction

  assign oq_full = (ocnt_r == 2'd2);
  assign adv     = !m_v_r || !oq_full;
  assign mq_pop  = adv && !mq_empty;
  assign o_push  = m_v_r && !oq_full;

  // divider stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
      m_v_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= mq_pop;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
      m_v_r <= v_r[NST-1];
    end
  end

  // divider stages after the input register, one quotient bit each, then offset in bank
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      n_r[0]   <= mq_rdata.logical;
      sd_r[0]  <= mq_rdata.side;
      for (int i = 1; i < NST; i++) begin
        {rem_r[i], n_r[i]} <= div_step(rem_r[i-1], n_r[i-1], cfg.share);
        sd_r[i] <= sd_r[i-1];
      end
      q_r      <= n_r[NST-1];
      ofs_r    <= OFS_W'(sd_r[NST-1].batch) * OFS_W'(cfg.share)
                  + OFS_W'(rem_r[NST-1]);
      m_side_r <= sd_r[NST-1];
    end
  end

  // field split, overflow checks and address packing
  always_comb begin
    logic [OFS_W-1:0]  word;
    logic [ROWF_W-1:0] row;
    logic [LOG_W-1:0]  tmp, bk, bg, ch_off;
    logic [LOG_W:0]    ch;
    logic [4:0]        chf;
    logic [COL_B:0]    col;
    logic [3:0]        lane;
    logic [63:0]       addr;
    logic              over;
    word   = ofs_r / WORD_ELEMS;
    row    = ROWF_W'(word / COLUMNS) + ROWF_W'(cfg.region_row);
    col    = (COL_B+1)'(word % COLUMNS);
    lane   = m_side_r.kind ? 4'(m_side_r.lane_k) : 4'(ofs_r % WORD_ELEMS);
    bk     = q_r % BANKS_PER_GROUP;
    tmp    = q_r / BANKS_PER_GROUP;
    bg     = tmp % BANK_GROUPS;
    ch_off = tmp / BANK_GROUPS;
    ch     = {1'b0, ch_off} + (LOG_W+1)'(cfg.first_channel);
    chf    = ch[4:0];
    over   = (ch_off >= LOG_W'(cfg.channels_used)) || (ch > (LOG_W+1)'(CH_MAX))
             || (row >= (ROWF_W'(1) << ROW_BITS));
    addr   = (64'(chf) << SH_CH)
           | ((64'(bg) & ((64'd1 << BG_B) - 64'd1)) << SH_BG)
           | ((64'(bk) & ((64'd1 << BK_B) - 64'd1)) << SH_BK)
           | ((64'(row) & ((64'd1 << ROW_BITS) - 64'd1)) << SH_ROW)
           | ((64'(col) & ((64'd1 << COL_B) - 64'd1)) << SH_COL);
    addr   = addr + 64'(lane) * 64'd2;
    res.data_out = m_side_r.value;
    if (cfg.share == '0) begin
      res.channel      = '0;
      res.bank_group   = '0;
      res.bank_num     = '0;
      res.dram_row     = '0;
      res.column       = '0;
      res.lane         = '0;
      res.byte_address = '0;
      res.status       = ST_SHARE0;
    end else begin
      res.channel      = chf;
      res.bank_group   = bg[1:0];
      res.bank_num     = bk[1:0];
      res.dram_row     = row[15:0];
      res.column       = col[4:0];
      res.lane         = lane;
      res.byte_address = addr[39:0];
      res.status       = over ? ST_OVERFLOW : ST_OK;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (o_push) owp_r <= !owp_r;
      if (out_pop && !out_empty) orp_r <= !orp_r;
      ocnt_r <= ocnt_r + 2'(o_push) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) oq_r[owp_r] <= res;
  end

  assign out_empty = (ocnt_r == 2'd0);
  assign out_word  = oq_r[orp_r];
endmodule

// File: hdl/kv_cache_scatter_addresser.sv
// top level of the kv cache scatter addresser
// throughput: one word per cycle while in_full stays low, set by the 38-stage pipelined share divider
// a configuration write holds in_full high while the share
// is recomputed by the serial divider in the register block
// reset (synchronous, rst_n low) loads register defaults and empties all queues
module kv_cache_scatter_addresser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  kvcs_pkg::in_word_t          in_word,
  output logic                        out_empty,
  input  logic                        out_pop,
  output kvcs_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [kvcs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kvcs_pkg::CFG_DW-1:0] cfg_data
);
  import kvcs_pkg::*;

  cfg_t      cfg;
  logic      busy, ready;
  logic      mq_push, mq_full, mq_pop, mq_empty;
  mid_word_t mq_wdata, mq_rdata;

  assign in_full = busy || !ready;

  kvcs_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cfg, .busy
  );

  kvcs_front u_front (
    .clk, .rst_n, .acc(in_push && !in_full), .in_word, .cfg, .ready,
    .mq_push, .mq_wdata, .mq_full
  );

  kvcs_midq u_midq (
    .clk, .rst_n, .push(mq_push), .wdata(mq_wdata), .full(mq_full),
    .pop(mq_pop), .rdata(mq_rdata), .empty(mq_empty)
  );

  kvcs_back u_back (
    .clk, .rst_n, .mq_rdata, .mq_empty, .mq_pop, .cfg,
    .out_empty, .out_pop, .out_word
  );
endmodule

// File: hdl/kvcs_checker.sv
// port-level checks for the kv cache scatter addresser, bound to the top level
module kvcs_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input kvcs_pkg::out_word_t out_word,
  input logic                cfg_we
);
  import kvcs_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a register write blocks input while the share is rederived
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_full)
    else $error("input open right after a configuration write");

  // status carries only defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.status == ST_OK || out_word.status == ST_SHARE0
                    || out_word.status == ST_OVERFLOW))
    else $error("undefined status code");

  // zero share gives a cleared address
  a_share0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status == ST_SHARE0) |->
      (out_word.byte_address == '0 && out_word.dram_row == '0
       && out_word.channel == '0 && out_word.lane == '0))
    else $error("address fields set with zero bank share");
endmodule

bind kv_cache_scatter_addresser kvcs_port_props u_kvcs_port_props (
  .clk, .rst_n, .in_full, .out_empty, .out_word, .cfg_we
);

// File: tb/kvcs_checker.sv
// checker that predicts and compares kv cache scatter addresser result words
module kvcs_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  kvcs_pkg::in_word_t          in_word,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  kvcs_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [kvcs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kvcs_pkg::CFG_DW-1:0] cfg_data,
  output int                          pending,
  output int                          fail_count
);
  import kvcs_pkg::*;

  // shadow copy of the configuration registers
  logic [63:0] hc_q, sl_q, hd_q, cu_q, fc_q, rr_q;
  out_word_t   addr_queue[$];

  assign pending = addr_queue.size();

  // address prediction for one element word
  function automatic out_word_t predict_addr(in_word_t w);
    out_word_t r;
    logic [63:0] per_batch, share, logical, lane, bank_idx, offset, wrd;
    logic [63:0] row, col, bk, tmp, bg, ch_off, ch, addr;
    bit over;
    r = '0;
    r.data_out = w.value;
    per_batch = hc_q * sl_q * hd_q;
    share = (cu_q != 0) ? per_batch / (cu_q * BANKS_PER_CH) : 0;
    if (share == 0) begin
      r.status = ST_SHARE0;
      return r;
    end
    if (w.kind) begin
      logical = w.head * (sl_q * hd_q) + w.seq_pos * hd_q
              + (w.dim_index - (w.dim_index % WORD_ELEMS));
      lane = w.dim_index % WORD_ELEMS;
    end else begin
      logical = w.head * (hd_q * sl_q) + w.dim_index * sl_q + w.seq_pos;
      lane = 0;
    end
    bank_idx = logical / share;
    offset = w.batch * share + (logical % share);
    wrd = offset / WORD_ELEMS;
    if (!w.kind) lane = offset % WORD_ELEMS;
    row = wrd / COLUMNS + rr_q;
    col = wrd % COLUMNS;
    bk = bank_idx % BANKS_PER_GROUP;
    tmp = bank_idx / BANKS_PER_GROUP;
    bg = tmp % BANK_GROUPS;
    ch_off = tmp / BANK_GROUPS;
    ch = ch_off + fc_q;
    over = (ch_off >= cu_q) || (ch > CH_MAX) || (row >= (64'd1 << ROW_BITS));
    addr = ((ch & 64'h1f) << SH_CH) | ((bg & 64'h3) << SH_BG) | ((bk & 64'h3) << SH_BK)
         | ((row & 64'hffff) << SH_ROW) | ((col & 64'h1f) << SH_COL);
    addr = addr + lane * 2;
    r.channel      = ch[4:0];
    r.bank_group   = bg[1:0];
    r.bank_num     = bk[1:0];
    r.dram_row     = row[15:0];
    r.column       = col[4:0];
    r.lane         = lane[3:0];
    r.byte_address = addr[39:0];
    r.status       = over ? ST_OVERFLOW : ST_OK;
    return r;
  endfunction

  // report one bad field
  task automatic report_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (fail_count < 10)
      $display("mismatch %s: expected %0h actual %0h", nm, exp_v, act_v);
    fail_count++;
  endtask

  // watch configuration, input and result channels
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      hc_q = 1; sl_q = 1; hd_q = 16; cu_q = 1; fc_q = 0; rr_q = 0;
      addr_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAD_COUNT:    hc_q = cfg_data[HC_W-1:0];
          REG_SEQ_LENGTH:    sl_q = cfg_data[SL_W-1:0];
          REG_HEAD_DIM:      hd_q = cfg_data[HD_W-1:0];
          REG_CHANNELS_USED: cu_q = cfg_data[CU_W-1:0];
          REG_FIRST_CHANNEL: fc_q = cfg_data[FC_W-1:0];
          REG_REGION_ROW:    rr_q = cfg_data[RR_W-1:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (addr_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_word);
          fail_count++;
        end else begin
          e = addr_queue.pop_front();
          if (e.channel != out_word.channel)
            report_field("channel", e.channel, out_word.channel);
          if (e.bank_group != out_word.bank_group)
            report_field("bank_group", e.bank_group, out_word.bank_group);
          if (e.bank_num != out_word.bank_num)
            report_field("bank_num", e.bank_num, out_word.bank_num);
          if (e.dram_row != out_word.dram_row)
            report_field("dram_row", e.dram_row, out_word.dram_row);
          if (e.column != out_word.column)
            report_field("column", e.column, out_word.column);
          if (e.lane != out_word.lane)
            report_field("lane", e.lane, out_word.lane);
          if (e.byte_address != out_word.byte_address)
            report_field("byte_address", e.byte_address, out_word.byte_address);
          if (e.data_out != out_word.data_out)
            report_field("data_out", e.data_out, out_word.data_out);
          if (e.status != out_word.status)
            report_field("status", e.status, out_word.status);
        end
      end
      if (in_push && !in_full) addr_queue.push_back(predict_addr(in_word));
    end
  end
endmodule

// File: tb/tb_kv_cache_scatter_addresser.sv
// stimulus and verdict for the kv cache scatter addresser
module tb_kv_cache_scatter_addresser;
  import kvcs_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  in_word_t            in_word = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  out_word_t           out_word;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;
  int                  pending;
  int                  fail_count;

  // current settings, mirrored for bounding random fields
  int unsigned hc, sl, hd;
  int          burst_left = 0;
  bit          long_hold_req = 0;
  int          hold_cnt = 0;
  int          pop_mode = 0;
  int          mode_cnt = 0;

  kv_cache_scatter_addresser u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kvcs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // receiver stall pattern with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_pop = 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 250;
      out_pop = 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        pop_mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(10, 80);
      end
      mode_cnt--;
      case (pop_mode)
        0: out_pop = 1'b1;
        1: out_pop = 1'($urandom_range(0, 1));
        default: out_pop = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // write all registers while the block is idle
  task automatic write_config(int unsigned h, int unsigned s, int unsigned d,
                              int unsigned c, int unsigned f, int unsigned r);
    logic [CFG_IW-1:0] idx[6];
    logic [CFG_DW-1:0] val[6];
    idx = '{REG_HEAD_COUNT, REG_SEQ_LENGTH, REG_HEAD_DIM,
            REG_CHANNELS_USED, REG_FIRST_CHANNEL, REG_REGION_ROW};
    val = '{CFG_DW'(h), CFG_DW'(s), CFG_DW'(d), CFG_DW'(c), CFG_DW'(f), CFG_DW'(r)};
    @(negedge clk);
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = idx[i];
      cfg_data = val[i];
    end
    @(negedge clk);
    cfg_we = 1'b0;
    hc = h; sl = s; hd = d;
  endtask

  // offer one word in bursts with random gaps
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_push = 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_push = 1'b1;
    in_word = w;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic in_word_t make_word(int unsigned k, int unsigned b, int unsigned h,
                                         int unsigned s, int unsigned d, int unsigned v);
    in_word_t w;
    w.kind = 1'(k); w.batch = 8'(b); w.head = 8'(h); w.seq_pos = 16'(s);
    w.dim_index = 10'(d); w.value = 16'(v);
    return w;
  endfunction

  // random element word, mostly inside the configured tensor
  function automatic in_word_t rand_word();
    in_word_t w;
    w = make_word($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 1023), $urandom_range(0, 65535));
    if ($urandom_range(0, 4) != 0) begin
      w.head = 8'($urandom_range(0, (hc > 256) ? 255 : hc - 1));
      w.seq_pos = 16'($urandom_range(0, (sl > 65536) ? 65535 : sl - 1));
      w.dim_index = 10'($urandom_range(0, (hd > 1024) ? 1023 : hd - 1));
      if ($urandom_range(0, 1)) w.batch = 8'($urandom_range(0, 3));
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: mid-size tensor, both kinds, field extremes, dim past head_dim
    write_config(4, 64, 64, 2, 3, 100);
    for (int k = 0; k < 2; k++) begin
      send_word(make_word(k, 0, 0, 0, 0, 0));
      send_word(make_word(k, 255, 255, 65535, 1023, 65535));
      send_word(make_word(k, 1, 3, 63, 63, 16'h5a5a));
      send_word(make_word(k, 0, 2, 17, 100, 16'ha5a5));
      send_word(make_word(k, 2, 1, 5, 31, 16'h8001));
    end
    write_config(1, 1, 1, 32, 0, 0);
    send_word(make_word(1, 7, 0, 0, 0, 16'hbeef));
    send_word(make_word(0, 255, 255, 65535, 1023, 16'hffff));
    write_config(256, 65536, 1024, 32, 31, 65535);
    send_word(make_word(0, 0, 0, 0, 0, 16'h1234));
    send_word(make_word(1, 255, 255, 65535, 1023, 16'h4321));
    write_config(1, 16, 16, 1, 0, 0);
    send_word(make_word(1, 0, 0, 15, 15, 16'h0f0f));
    send_word(make_word(0, 0, 0, 15, 15, 16'hf0f0));

    // random phases over fixed and random settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_config(4, 64, 64, 2, 3, 100);
        1: write_config(1, 1, 1, 32, 0, 0);
        2: write_config(256, 65536, 1024, 32, 31, 65535);
        3: write_config(1, 16, 16, 1, 0, 0);
        4: write_config(8, 128, 128, 4, 28, 65000);
        default: write_config($urandom_range(1, 256), $urandom_range(1, 65536),
                              $urandom_range(1, 1024), $urandom_range(1, 32),
                              $urandom_range(0, 31), $urandom_range(0, 65535));
      endcase
      if (p == 0) long_hold_req = 1;
      for (int i = 0; i < 150; i++) begin
        w = rand_word();
        send_word(w);
      end
    end
    @(negedge clk);
    in_push = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: filelist.f
hdl/kvcs_pkg.sv
hdl/kvcs_cfg.sv
hdl/kvcs_front.sv
hdl/kvcs_midq.sv
hdl/kvcs_back.sv
hdl/kv_cache_scatter_addresser.sv
hdl/kvcs_checker.sv
tb/kvcs_checker.sv
tb/tb_kv_cache_scatter_addresser.sv
